/* sv/gss_pkg.sv */
// shared types and constants for the gimbal slew/scan controller
// no dependencies; used by the channel interfaces and the top level
package gss_pkg;

  typedef logic signed [15:0] angle_t;
  typedef logic [14:0]        temp_t;
  typedef logic [15:0]        rate_t;
  typedef logic [2:0]         opcode_t;
  typedef logic [2:0]         mode_t;
  typedef logic [2:0]         fault_t;
  typedef logic [2:0]         reg_idx_t;

  // command opcodes
  localparam opcode_t OP_TICK       = 3'd0;
  localparam opcode_t OP_POWER      = 3'd1;
  localparam opcode_t OP_INIT       = 3'd2;
  localparam opcode_t OP_SET_TARGET = 3'd3;
  localparam opcode_t OP_SCAN_START = 3'd4;
  localparam opcode_t OP_SCAN_STOP  = 3'd5;
  localparam opcode_t OP_FAULT      = 3'd6;
  localparam opcode_t OP_READ       = 3'd7;

  // operating modes
  localparam mode_t MODE_OFFLINE = 3'd0;
  localparam mode_t MODE_INIT    = 3'd1;
  localparam mode_t MODE_READY   = 3'd2;
  localparam mode_t MODE_SCAN    = 3'd3;
  localparam mode_t MODE_FAULT   = 3'd4;

  // fault codes with a meaning of their own
  localparam fault_t FAULT_NONE      = 3'd0;
  localparam fault_t FAULT_OVER_TEMP = 3'd1;

  // register indexes
  localparam reg_idx_t REG_PAN_MIN   = 3'd0;
  localparam reg_idx_t REG_PAN_MAX   = 3'd1;
  localparam reg_idx_t REG_TILT_MIN  = 3'd2;
  localparam reg_idx_t REG_TILT_MAX  = 3'd3;
  localparam reg_idx_t REG_SLEW_RATE = 3'd4;
  localparam reg_idx_t REG_SCAN_RATE = 3'd5;

  // register reset values
  localparam angle_t PAN_MIN_RST   = -16'sd9000;
  localparam angle_t PAN_MAX_RST   = 16'sd9000;
  localparam angle_t TILT_MIN_RST  = -16'sd4500;
  localparam angle_t TILT_MAX_RST  = 16'sd4500;
  localparam rate_t  SLEW_RATE_RST = 16'd6000;
  localparam rate_t  SCAN_RATE_RST = 16'd3000;

  // temperatures in q8 celsius
  localparam temp_t TEMP_IDLE = 15'd7680;   // 30 C
  localparam temp_t TEMP_HOT  = 15'd10752;  // 42 C
  localparam temp_t TEMP_OVER = 15'd24320;  // 95 C

  // 0.15 per second in units of 1/65536
  localparam logic [15:0] TEMP_GAIN = 16'd9830;

  // settle window around zero for leaving initializing, centidegrees
  localparam angle_t NEAR_ZERO = 16'sd5;

endpackage

/* sv/gss_cmd_if.sv */
// command channel of the gimbal controller: valid/ready plus one command beat
// depends on gss_pkg for field types
interface gss_cmd_if;
  logic               valid;
  logic               ready;
  gss_pkg::opcode_t   opcode;
  logic               power_on;
  gss_pkg::angle_t    pan_request;
  gss_pkg::angle_t    tilt_request;
  gss_pkg::fault_t    fault_code;
  logic [15:0]        elapsed_time;

  modport source (
    output valid, opcode, power_on, pan_request, tilt_request, fault_code, elapsed_time,
    input  ready
  );

  modport sink (
    input  valid, opcode, power_on, pan_request, tilt_request, fault_code, elapsed_time,
    output ready
  );
endinterface

/* sv/gss_res_if.sv */
// result channel of the gimbal controller: valid/ready plus one status beat
// depends on gss_pkg for field types
interface gss_res_if;
  logic             valid;
  logic             ready;
  logic             accepted;
  gss_pkg::mode_t   mode;
  gss_pkg::fault_t  active_fault;
  gss_pkg::angle_t  pan_angle;
  gss_pkg::angle_t  tilt_angle;
  gss_pkg::angle_t  pan_target;
  gss_pkg::angle_t  tilt_target;
  gss_pkg::temp_t   temperature;

  modport source (
    output valid, accepted, mode, active_fault, pan_angle, tilt_angle,
           pan_target, tilt_target, temperature,
    input  ready
  );

  modport sink (
    input  valid, accepted, mode, active_fault, pan_angle, tilt_angle,
           pan_target, tilt_target, temperature,
    output ready
  );
endinterface

/* sv/gimbal_slew_scan_controller_top.sv */
// top level of the gimbal slew/scan controller: sequencer, shared multiplier, state
// depends on gss_pkg, gss_cmd_if and gss_res_if

// Pan/tilt gimbal controller. Each command beat on cmd yields exactly one status
// beat on res, showing the state after the command. Non-tick commands (power,
// initialize, set target, scan start/stop, fault, read) go from the cycle that
// accepts the beat straight to the result state, which loads the output register.
// A tick runs through one shared 31x16 multiplier four times in a row (scan
// step, slew step, temperature distance times elapsed time, then times the 0.15/s
// gain); the scan, slew and final temperature products are applied in the cycle
// after they are formed. Either kind of command also waits in the result state
// while the output register still holds an unread beat. cmd.ready is high
// only while the sequencer is idle, so a new command is taken in the cycle after
// the previous result has gone into the output register; that register holds the
// result while res.ready is low, and the next command is already being worked on
// meanwhile. Limits and rates sit on an APB-style port at byte addresses 0,4,...,20
// (pan_min, pan_max, tilt_min, tilt_max, slew_rate, scan_rate); pready is always
// high, and writes are meant to happen only while no command is in flight.
module gimbal_slew_scan_controller_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  gss_cmd_if.sink     cmd,
  gss_res_if.source   res
);

  // sequencer states
  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_MUL_SCAN   = 3'd1;  // scan_rate * dt
  localparam logic [2:0] S_APPLY_SCAN = 3'd2;  // move pan target, form slew_rate * dt
  localparam logic [2:0] S_APPLY_SLEW = 3'd3;  // move angles, form |distance| * dt
  localparam logic [2:0] S_MUL_TEMP   = 3'd4;  // times the gain
  localparam logic [2:0] S_APPLY_TEMP = 3'd5;  // move temperature
  localparam logic [2:0] S_DONE       = 3'd6;  // load the output register

  // configuration registers
  gss_pkg::angle_t pan_min, pan_max, tilt_min, tilt_max;
  gss_pkg::rate_t  slew_rate, scan_rate;

  // controller state
  logic [2:0]       state;
  gss_pkg::mode_t   mode_reg;
  gss_pkg::fault_t  fault_reg;
  gss_pkg::angle_t  pan_now, tilt_now, pan_goal, tilt_goal;
  logic             scan_backward;
  gss_pkg::temp_t   temp_now;

  // per-command holding registers
  logic             ok_q;
  gss_pkg::opcode_t op_q;
  logic [15:0]      dt_q;
  logic [46:0]      prod;

  // output register
  logic             res_valid;
  logic             out_accepted;
  gss_pkg::mode_t   out_mode;
  gss_pkg::fault_t  out_fault;
  gss_pkg::angle_t  out_pan_angle, out_tilt_angle, out_pan_target, out_tilt_target;
  gss_pkg::temp_t   out_temp;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  logic               cfg_wr;
  gss_pkg::reg_idx_t  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_min   <= gss_pkg::PAN_MIN_RST;
      pan_max   <= gss_pkg::PAN_MAX_RST;
      tilt_min  <= gss_pkg::TILT_MIN_RST;
      tilt_max  <= gss_pkg::TILT_MAX_RST;
      slew_rate <= gss_pkg::SLEW_RATE_RST;
      scan_rate <= gss_pkg::SCAN_RATE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gss_pkg::REG_PAN_MIN:   pan_min   <= pwdata[15:0];
        gss_pkg::REG_PAN_MAX:   pan_max   <= pwdata[15:0];
        gss_pkg::REG_TILT_MIN:  tilt_min  <= pwdata[15:0];
        gss_pkg::REG_TILT_MAX:  tilt_max  <= pwdata[15:0];
        gss_pkg::REG_SLEW_RATE: slew_rate <= pwdata[15:0];
        gss_pkg::REG_SCAN_RATE: scan_rate <= pwdata[15:0];
        default: ;  // addresses past the register list are ignored
      endcase
    end
  end

  // read back, angles sign extended
  always_comb begin
    unique case (cfg_idx)
      gss_pkg::REG_PAN_MIN:   prdata = {{16{pan_min[15]}}, pan_min};
      gss_pkg::REG_PAN_MAX:   prdata = {{16{pan_max[15]}}, pan_max};
      gss_pkg::REG_TILT_MIN:  prdata = {{16{tilt_min[15]}}, tilt_min};
      gss_pkg::REG_TILT_MAX:  prdata = {{16{tilt_max[15]}}, tilt_max};
      gss_pkg::REG_SLEW_RATE: prdata = {16'd0, slew_rate};
      gss_pkg::REG_SCAN_RATE: prdata = {16'd0, scan_rate};
      default:                prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  // clamp with the min test first, so reversed limits give min below min, else max
  function automatic gss_pkg::angle_t clamp_to(gss_pkg::angle_t x, gss_pkg::angle_t lo,
                                               gss_pkg::angle_t hi);
    gss_pkg::angle_t r;
    if (x < lo)      r = lo;
    else if (x < hi) r = x;
    else             r = hi;
    return r;
  endfunction

  // move cur toward goal by at most s
  function automatic gss_pkg::angle_t slew_to(gss_pkg::angle_t cur, gss_pkg::angle_t goal,
                                              logic [16:0] s);
    logic signed [17:0] d;
    logic signed [17:0] sp;
    d  = {{2{goal[15]}}, goal} - {{2{cur[15]}}, cur};
    sp = {1'b0, s};
    if (d > sp)  d = sp;
    if (d < -sp) d = -sp;
    return cur + d[15:0];
  endfunction

  function automatic logic near_zero(gss_pkg::angle_t a);
    return (a <= gss_pkg::NEAR_ZERO) && (a >= -gss_pkg::NEAR_ZERO);
  endfunction

  // ---------------------------------------------------------------------------
  // shared multiplier, product registered every cycle
  // ---------------------------------------------------------------------------
  logic [30:0] mul_a;
  logic [15:0] mul_b;
  logic [46:0] mul_p;

  // temperature distance, valid while temp_now and mode_reg hold
  gss_pkg::temp_t      temp_target;
  logic signed [16:0]  temp_dist;
  logic signed [16:0]  dist_neg;
  logic [15:0]         mag;

  assign temp_target = (mode_reg == gss_pkg::MODE_SCAN) ? gss_pkg::TEMP_HOT
                                                        : gss_pkg::TEMP_IDLE;
  assign temp_dist   = {2'b00, temp_target} - {2'b00, temp_now};
  assign dist_neg    = -temp_dist;
  assign mag         = temp_dist[16] ? dist_neg[15:0] : temp_dist[15:0];

  always_comb begin
    unique case (state)
      S_MUL_SCAN: begin
        mul_a = {15'd0, scan_rate};
        mul_b = dt_q;
      end
      S_APPLY_SCAN: begin
        mul_a = {15'd0, slew_rate};
        mul_b = dt_q;
      end
      S_APPLY_SLEW: begin
        mul_a = {15'd0, mag};
        mul_b = dt_q;
      end
      S_MUL_TEMP: begin
        mul_a = prod[30:0];
        mul_b = gss_pkg::TEMP_GAIN;
      end
      default: begin
        mul_a = 31'd0;
        mul_b = 16'd0;
      end
    endcase
  end

  assign mul_p = {16'd0, mul_a} * {31'd0, mul_b};

  always_ff @(posedge clk) begin
    prod <= mul_p;
  end

  // ---------------------------------------------------------------------------
  // tick datapath off the registered product
  // ---------------------------------------------------------------------------
  logic [46:0]        step_rnd;
  logic [16:0]        step;
  logic signed [18:0] scan_g;
  logic signed [18:0] pan_min_x, pan_max_x;
  logic               scan_hit_max, scan_hit_min;
  gss_pkg::angle_t    scan_goal_next;
  gss_pkg::angle_t    pan_slew, tilt_slew;
  logic [46:0]        temp_rnd;
  gss_pkg::temp_t     temp_delta;
  gss_pkg::temp_t     temp_apply;

  // round half up to whole centidegrees
  assign step_rnd = prod + 47'd32768;
  assign step     = step_rnd[32:16];

  assign pan_min_x = {{3{pan_min[15]}}, pan_min};
  assign pan_max_x = {{3{pan_max[15]}}, pan_max};
  assign scan_g    = scan_backward ? ({{3{pan_goal[15]}}, pan_goal} - {2'b00, step})
                                   : ({{3{pan_goal[15]}}, pan_goal} + {2'b00, step});

  // upper bound wins when both limits are crossed
  assign scan_hit_max   = scan_g >= pan_max_x;
  assign scan_hit_min   = scan_g <= pan_min_x;
  assign scan_goal_next = scan_hit_max ? pan_max :
                          scan_hit_min ? pan_min : scan_g[15:0];

  assign pan_slew  = slew_to(pan_now, pan_goal, step);
  assign tilt_slew = slew_to(tilt_now, tilt_goal, step);

  // drop the 32 fraction bits with round half up
  assign temp_rnd   = prod + 47'd2147483648;
  assign temp_delta = temp_rnd[46:32];
  assign temp_apply = temp_dist[16] ? (temp_now - temp_delta) : (temp_now + temp_delta);

  // ---------------------------------------------------------------------------
  // sequencer and controller state
  // ---------------------------------------------------------------------------
  logic motion_ok;
  assign motion_ok = (mode_reg == gss_pkg::MODE_READY) || (mode_reg == gss_pkg::MODE_SCAN);

  assign cmd.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mode_reg      <= gss_pkg::MODE_OFFLINE;
      fault_reg     <= gss_pkg::FAULT_NONE;
      pan_now       <= '0;
      tilt_now      <= '0;
      pan_goal      <= '0;
      tilt_goal     <= '0;
      scan_backward <= 1'b0;
      temp_now      <= gss_pkg::TEMP_IDLE;
      res_valid     <= 1'b0;
      ok_q          <= 1'b0;
      op_q          <= gss_pkg::OP_TICK;
    end else begin
      // the result state reloads the register itself when the old beat leaves
      if (res_valid && res.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            dt_q  <= cmd.elapsed_time;
            op_q  <= cmd.opcode;
            ok_q  <= 1'b1;
            state <= S_DONE;
            case (cmd.opcode)
              gss_pkg::OP_TICK: begin
                state <= S_MUL_SCAN;
              end
              gss_pkg::OP_POWER: begin
                if (!cmd.power_on) begin
                  mode_reg  <= gss_pkg::MODE_OFFLINE;
                  fault_reg <= gss_pkg::FAULT_NONE;
                end else if (mode_reg == gss_pkg::MODE_OFFLINE) begin
                  mode_reg <= gss_pkg::MODE_READY;
                end else begin
                  ok_q <= (mode_reg != gss_pkg::MODE_FAULT);
                end
              end
              gss_pkg::OP_INIT: begin
                if (mode_reg == gss_pkg::MODE_OFFLINE) begin
                  ok_q <= 1'b0;
                end else begin
                  fault_reg <= gss_pkg::FAULT_NONE;
                  pan_goal  <= '0;
                  tilt_goal <= '0;
                  mode_reg  <= gss_pkg::MODE_INIT;
                end
              end
              gss_pkg::OP_SET_TARGET: begin
                if (!motion_ok) begin
                  ok_q <= 1'b0;
                end else begin
                  pan_goal  <= clamp_to(cmd.pan_request, pan_min, pan_max);
                  tilt_goal <= clamp_to(cmd.tilt_request, tilt_min, tilt_max);
                  mode_reg  <= gss_pkg::MODE_READY;
                end
              end
              gss_pkg::OP_SCAN_START: begin
                if (!motion_ok) ok_q <= 1'b0;
                else            mode_reg <= gss_pkg::MODE_SCAN;
              end
              gss_pkg::OP_SCAN_STOP: begin
                if (mode_reg != gss_pkg::MODE_SCAN) begin
                  ok_q <= 1'b0;
                end else begin
                  pan_goal <= pan_now;
                  mode_reg <= gss_pkg::MODE_READY;
                end
              end
              gss_pkg::OP_FAULT: begin
                fault_reg <= cmd.fault_code;
                if (cmd.fault_code == gss_pkg::FAULT_OVER_TEMP) begin
                  temp_now <= gss_pkg::TEMP_OVER;
                end
                if (cmd.fault_code == gss_pkg::FAULT_NONE) begin
                  if (mode_reg != gss_pkg::MODE_OFFLINE) mode_reg <= gss_pkg::MODE_READY;
                end else begin
                  mode_reg <= gss_pkg::MODE_FAULT;
                end
              end
              gss_pkg::OP_READ: ;  // snapshot only
              default: ;
            endcase
          end
        end

        S_MUL_SCAN: begin
          state <= S_APPLY_SCAN;
        end

        S_APPLY_SCAN: begin
          if (mode_reg == gss_pkg::MODE_SCAN) begin
            pan_goal <= scan_goal_next;
            if (scan_hit_max)      scan_backward <= 1'b1;
            else if (scan_hit_min) scan_backward <= 1'b0;
          end
          state <= S_APPLY_SLEW;
        end

        S_APPLY_SLEW: begin
          // no motion while offline or faulted
          if (mode_reg != gss_pkg::MODE_OFFLINE && mode_reg != gss_pkg::MODE_FAULT) begin
            pan_now  <= pan_slew;
            tilt_now <= tilt_slew;
            if (mode_reg == gss_pkg::MODE_INIT && near_zero(pan_slew) &&
                near_zero(tilt_slew)) begin
              mode_reg <= gss_pkg::MODE_READY;
            end
          end
          state <= S_MUL_TEMP;
        end

        S_MUL_TEMP: begin
          state <= S_APPLY_TEMP;
        end

        S_APPLY_TEMP: begin
          temp_now <= temp_apply;
          state    <= S_DONE;
        end

        S_DONE: begin
          // wait for the output register to free up
          if (!res_valid || res.ready) begin
            res_valid       <= 1'b1;
            out_accepted    <= ok_q;
            out_mode        <= mode_reg;
            out_fault       <= fault_reg;
            out_pan_angle   <= pan_now;
            out_tilt_angle  <= tilt_now;
            out_pan_target  <= pan_goal;
            out_tilt_target <= tilt_goal;
            out_temp        <= temp_now;
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid        = res_valid;
  assign res.accepted     = out_accepted;
  assign res.mode         = out_mode;
  assign res.active_fault = out_fault;
  assign res.pan_angle    = out_pan_angle;
  assign res.tilt_angle   = out_tilt_angle;
  assign res.pan_target   = out_pan_target;
  assign res.tilt_target  = out_tilt_target;
  assign res.temperature  = out_temp;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // commands other than tick need no arithmetic pass
  a_cmd_short: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && cmd.opcode != gss_pkg::OP_TICK) |=> (state == S_DONE))
    else $error("non-tick command did not go straight to result");

  // a tick is never rejected
  a_tick_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && op_q == gss_pkg::OP_TICK) |-> ok_q)
    else $error("tick result marked as rejected");

  // exponential approach keeps the temperature between the idle target and the over-temperature value
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    (temp_now >= gss_pkg::TEMP_IDLE) && (temp_now <= gss_pkg::TEMP_OVER))
    else $error("temperature left its range");

  // angles move only in the slew step
  a_angle_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_APPLY_SLEW) |=> ($stable(pan_now) && $stable(tilt_now)))
    else $error("angle changed outside slew step");

  // a new result beat is only raised from the result state
  a_res_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside result state");

endmodule
